[sv/hdu_pkg.sv]
// Package for the haversine distance unit: widths, fixed-point constants,
// CORDIC arctangent table and shared types. No dependencies.
`default_nettype none

package hdu_pkg;

   // port field widths
   localparam int LAT_W  = 28;
   localparam int LON_W  = 29;
   localparam int DIST_W = 23;

   // angle format at the ports: degrees * 2^ANGLE_FRAC_BITS
   localparam int ANGLE_FRAC_BITS = 20;
   localparam int CORDIC_STAGES_DEFAULT = 24;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic {
      CSR_REF_LATITUDE  = 1'b0,
      CSR_REF_LONGITUDE = 1'b1
   } csr_index_type;

   // angle front end
   localparam int ANG_W   = 31;
   localparam int MAG_W   = 28;
   localparam int PROD_W  = 60;
   localparam int U_W     = 37;
   localparam int Q_W     = 32;
   localparam int REM_W   = 38;
   localparam int RECIP_SHIFT = 37;
   localparam logic [31:0] PI_Q30    = 32'd3373259426;
   localparam logic [31:0] RECIP_45  = 32'd3054198966;
   localparam int DIV_45 = 45;

   typedef logic signed [ANG_W-1:0] ang_type;

   typedef struct packed {
      logic [MAG_W-1:0] mag;
      logic             rneg;
      logic             cneg;
   } fold_type;

   // CORDIC datapath
   localparam int CORDIC_W = 34;
   typedef logic signed [CORDIC_W-1:0] cordic_word_type;
   typedef logic signed [63:0] prq_type;

   localparam cordic_word_type CORDIC_GAIN_Q30 = 34'sd652032874;

   localparam logic [29:0] ATAN_TAB [10] = '{
      30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
      30'd33543516,  30'd16775851,  30'd8388437,   30'd4194283,   30'd2097149
   };

   function automatic cordic_word_type atan_q(input int unsigned idx);
      cordic_word_type r;
      if (idx < 10) begin
         r = cordic_word_type'(ATAN_TAB[idx[3:0]]);
      end else if (idx <= 30) begin
         r = cordic_word_type'(CORDIC_W'(1) << (30 - idx));
      end else begin
         r = '0;
      end
      return r;
   endfunction

   // haversine term and roots
   localparam int A_W = 31;
   localparam logic [A_W-1:0] Q30_ONE = 31'h4000_0000;
   localparam int SQRT_STEPS = 31;
   localparam int SQ_W = 62;

   // distance scaling
   localparam int DP_W = 53;
   localparam logic [21:0] DIST_SCALE = 22'd3261952;
   localparam logic [DIST_W-1:0] DIST_MAX = 23'd5123863;

endpackage

`default_nettype wire

[sv/hdu_cordic.sv]
// Pipelined CORDIC, one iteration per register stage, rotation or vectoring.
// Depends on hdu_pkg (word type, arctangent table).
`default_nettype none

module hdu_cordic #(
   parameter int STAGES    = hdu_pkg::CORDIC_STAGES_DEFAULT,
   parameter int LANES     = 1,
   parameter bit VECTORING = 1'b0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     enable,
   input  logic                     in_valid,
   input  hdu_pkg::cordic_word_type in_x [LANES],
   input  hdu_pkg::cordic_word_type in_y [LANES],
   input  hdu_pkg::cordic_word_type in_z [LANES],
   output logic                     out_valid,
   output hdu_pkg::cordic_word_type out_x [LANES],
   output hdu_pkg::cordic_word_type out_y [LANES],
   output hdu_pkg::cordic_word_type out_z [LANES]
);
   import hdu_pkg::*;

   cordic_word_type x_ff [STAGES][LANES];
   cordic_word_type y_ff [STAGES][LANES];
   cordic_word_type z_ff [STAGES][LANES];
   logic            valid_ff [STAGES];

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      cordic_word_type x_src [LANES];
      cordic_word_type y_src [LANES];
      cordic_word_type z_src [LANES];
      logic            valid_src;

      if (i == 0) begin : g_head
         assign x_src     = in_x;
         assign y_src     = in_y;
         assign z_src     = in_z;
         assign valid_src = in_valid;
      end else begin : g_body
         assign x_src     = x_ff[i-1];
         assign y_src     = y_ff[i-1];
         assign z_src     = z_ff[i-1];
         assign valid_src = valid_ff[i-1];
      end

      for (genvar l = 0; l < LANES; l++) begin : g_lane
         logic            turn;
         cordic_word_type x_in;
         cordic_word_type y_in;
         cordic_word_type z_in;

         // rotation steers on the residual angle, vectoring on the sign of y
         assign turn = VECTORING ? y_src[l][CORDIC_W-1] : !z_src[l][CORDIC_W-1];

         always_comb begin
            if (turn) begin
               x_in = x_src[l] - (y_src[l] >>> i);
               y_in = y_src[l] + (x_src[l] >>> i);
               z_in = z_src[l] - atan_q(i);
            end else begin
               x_in = x_src[l] + (y_src[l] >>> i);
               y_in = y_src[l] - (x_src[l] >>> i);
               z_in = z_src[l] + atan_q(i);
            end
         end

         always_ff @(posedge clock) begin
            if (enable) begin
               x_ff[i][l] <= x_in;
               y_ff[i][l] <= y_in;
               z_ff[i][l] <= z_in;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (enable) begin
            valid_ff[i] <= valid_src;
         end
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_x     = x_ff[STAGES-1];
   assign out_y     = y_ff[STAGES-1];
   assign out_z     = z_ff[STAGES-1];

endmodule

`default_nettype wire

[sv/haversine_distance_unit.sv]
// Top level of the haversine distance unit: reference registers, angle front
// end, products, square roots and distance scaling. Depends on hdu_pkg, hdu_cordic.
`default_nettype none

// Channel   | Direction | Handshake             | Payload
// ----------+-----------+-----------------------+---------------------------------------
// request   | in        | req_valid / req_stall | req_query_latitude, req_query_longitude
// response  | out       | rsp_valid / rsp_stall | rsp_distance_km
// register  | in/out    | APB psel/penable      | paddr, pwdata, prdata, pready
//
// One item enters per cycle while req_stall is low; the pipe depth is set by
// the two CORDIC pipes and the 31 digit steps of the roots.
// Reset is synchronous and clears the valid bits and both reference registers.
// A stall on the response freezes the pipe only when the output register and
// the stage before it both hold an item; until then items keep entering.

module haversine_distance_unit #(
   parameter int CORDIC_STAGES = hdu_pkg::CORDIC_STAGES_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [hdu_pkg::LAT_W-1:0]      req_query_latitude,
   input  logic signed [hdu_pkg::LON_W-1:0]      req_query_longitude,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic        [hdu_pkg::DIST_W-1:0]     rsp_distance_km,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic        [hdu_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic        [hdu_pkg::CSR_DATA_W-1:0] pwdata,
   output logic        [hdu_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                  pready
);
   import hdu_pkg::*;

   localparam int LANES = 4;

   // ---------------------------------------------------------------- registers
   logic signed [LAT_W-1:0] ref_lat_ff;
   logic signed [LON_W-1:0] ref_lon_ff;
   csr_index_type           csr_index;

   assign pready    = 1'b1;
   assign csr_index = csr_index_type'(paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_lat_ff <= '0;
         ref_lon_ff <= '0;
      end else if (psel && penable && pwrite) begin
         case (csr_index)
            CSR_REF_LATITUDE:  ref_lat_ff <= pwdata[LAT_W-1:0];
            CSR_REF_LONGITUDE: ref_lon_ff <= pwdata[LON_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_REF_LATITUDE:  prdata = {{(CSR_DATA_W-LAT_W){1'b0}}, ref_lat_ff};
         CSR_REF_LONGITUDE: prdata = {{(CSR_DATA_W-LON_W){1'b0}}, ref_lon_ff};
         default:           prdata = '0;
      endcase
   end

   // --------------------------------------------------------- pipe advance
   logic en;
   logic d_valid_ff;
   logic out_valid_ff;
   logic [DIST_W-1:0] d_ff;
   logic [DIST_W-1:0] out_dist_ff;

   // hold everything only when a finished item has nowhere to go
   assign en        = !(d_valid_ff && out_valid_ff && rsp_stall);
   assign req_stall = !en;

   // ---------------------------------------------------- stage 1: angles
   // lane 0: half latitude difference, lane 1: half longitude difference,
   // lane 2: reference latitude, lane 3: query latitude
   ang_type st1_ang_ff [LANES];
   logic    st1_valid_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         st1_ang_ff[0] <= ang_type'(req_query_latitude) - ang_type'(ref_lat_ff);
         st1_ang_ff[1] <= ang_type'(req_query_longitude) - ang_type'(ref_lon_ff);
         st1_ang_ff[2] <= ang_type'(ref_lat_ff);
         st1_ang_ff[3] <= ang_type'(req_query_latitude);
      end
   end

   function automatic fold_type fold(input ang_type ang, input ang_type half);
      ang_type  quarter;
      ang_type  r;
      fold_type f;
      quarter = half >>> 1;
      r       = ang;
      if (ang >= half) begin
         r = ang - (half <<< 1);
      end else if (ang < -half) begin
         r = ang + (half <<< 1);
      end
      f.cneg = 1'b0;
      if (r > quarter) begin
         r      = half - r;
         f.cneg = 1'b1;
      end else if (r < -quarter) begin
         r      = -half - r;
         f.cneg = 1'b1;
      end
      f.rneg = r[ANG_W-1];
      f.mag  = f.rneg ? MAG_W'(-r) : MAG_W'(r);
      return f;
   endfunction

   // --------------------------------------- stages 2..7: degrees to radians
   fold_type               st2_fold_ff [LANES];
   logic [PROD_W-1:0]      st3_prod_ff [LANES];
   logic [U_W-1:0]         st4_u_ff    [LANES];
   logic [63:0]            st5_pl_ff   [LANES];
   logic [U_W-1:0]         st5_ph_ff   [LANES];
   logic [U_W-1:0]         st5_u_ff    [LANES];
   logic [Q_W-1:0]         st6_q_ff    [LANES];
   logic [U_W-1:0]         st6_u_ff    [LANES];
   logic                   st3_rneg_ff [LANES];
   logic                   st4_rneg_ff [LANES];
   logic                   st5_rneg_ff [LANES];
   logic                   st6_rneg_ff [LANES];
   logic                   st3_cneg_ff [LANES];
   logic                   st4_cneg_ff [LANES];
   logic                   st5_cneg_ff [LANES];
   logic                   st6_cneg_ff [LANES];
   logic                   st7_cneg_ff [LANES];
   cordic_word_type        st7_z_ff    [LANES];
   logic                   front_valid_ff [2:7];

   for (genvar l = 0; l < LANES; l++) begin : g_front
      localparam int      FB   = (l < 2) ? ANGLE_FRAC_BITS + 1 : ANGLE_FRAC_BITS;
      localparam ang_type HALF = ang_type'(64'd180 << FB);
      localparam logic [PROD_W-1:0] RND = PROD_W'(64'd90 << FB);

      logic [68:0]      sum6;
      logic [REM_W-1:0] rem7;
      logic [Q_W-1:0]   rad7;

      assign sum6 = {st5_ph_ff[l], 32'b0} + 69'(st5_pl_ff[l]);
      assign rem7 = REM_W'(st6_u_ff[l]) - REM_W'(st6_q_ff[l]) * REM_W'(DIV_45);
      assign rad7 = (rem7 >= REM_W'(DIV_45)) ? st6_q_ff[l] + Q_W'(1) : st6_q_ff[l];

      always_ff @(posedge clock) begin
         if (en) begin
            st2_fold_ff[l] <= fold(st1_ang_ff[l], HALF);
            // magnitude times pi
            st3_prod_ff[l] <= PROD_W'(st2_fold_ff[l].mag) * PROD_W'(PI_Q30);
            st3_rneg_ff[l] <= st2_fold_ff[l].rneg;
            st3_cneg_ff[l] <= st2_fold_ff[l].cneg;
            // round and drop the 2^fb and a factor four of the 180
            st4_u_ff[l]    <= U_W'((st3_prod_ff[l] + RND) >> (FB + 2));
            st4_rneg_ff[l] <= st3_rneg_ff[l];
            st4_cneg_ff[l] <= st3_cneg_ff[l];
            // divide by 45 through the reciprocal, split into two products
            st5_pl_ff[l]   <= 64'(st4_u_ff[l][31:0]) * 64'(RECIP_45);
            st5_ph_ff[l]   <= U_W'(st4_u_ff[l][U_W-1:32]) * U_W'(RECIP_45);
            st5_u_ff[l]    <= st4_u_ff[l];
            st5_rneg_ff[l] <= st4_rneg_ff[l];
            st5_cneg_ff[l] <= st4_cneg_ff[l];
            st6_q_ff[l]    <= sum6[68:RECIP_SHIFT];
            st6_u_ff[l]    <= st5_u_ff[l];
            st6_rneg_ff[l] <= st5_rneg_ff[l];
            st6_cneg_ff[l] <= st5_cneg_ff[l];
            // estimate may sit one low: correct, then restore the sign
            st7_z_ff[l]    <= st6_rneg_ff[l] ? -cordic_word_type'(rad7)
                                             : cordic_word_type'(rad7);
            st7_cneg_ff[l] <= st6_cneg_ff[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st1_valid_ff <= 1'b0;
         for (int k = 2; k <= 7; k++) begin
            front_valid_ff[k] <= 1'b0;
         end
      end else if (en) begin
         st1_valid_ff      <= req_valid;
         front_valid_ff[2] <= st1_valid_ff;
         for (int k = 3; k <= 7; k++) begin
            front_valid_ff[k] <= front_valid_ff[k-1];
         end
      end
   end

   // ------------------------------------------------ sine / cosine CORDIC
   cordic_word_type rot_x_src [LANES];
   cordic_word_type rot_y_src [LANES];
   cordic_word_type rot_x [LANES];
   cordic_word_type rot_y [LANES];
   cordic_word_type rot_z [LANES];
   logic            rot_valid;

   for (genvar l = 0; l < LANES; l++) begin : g_rot_src
      assign rot_x_src[l] = CORDIC_GAIN_Q30;
      assign rot_y_src[l] = '0;
   end

   hdu_cordic #(
      .STAGES    (CORDIC_STAGES),
      .LANES     (LANES),
      .VECTORING (1'b0)
   ) u_rot (
      .clock     (clock),
      .reset     (reset),
      .enable    (en),
      .in_valid  (front_valid_ff[7]),
      .in_x      (rot_x_src),
      .in_y      (rot_y_src),
      .in_z      (st7_z_ff),
      .out_valid (rot_valid),
      .out_x     (rot_x),
      .out_y     (rot_y),
      .out_z     (rot_z)
   );

   // cosine sign flags ride alongside the rotation pipe
   logic [1:0] cneg_line_ff [CORDIC_STAGES];

   always_ff @(posedge clock) begin
      if (en) begin
         cneg_line_ff[0] <= {st7_cneg_ff[3], st7_cneg_ff[2]};
         for (int k = 1; k < CORDIC_STAGES; k++) begin
            cneg_line_ff[k] <= cneg_line_ff[k-1];
         end
      end
   end

   // ---------------------------------------------- haversine term products
   function automatic cordic_word_type round_q30(input prq_type p);
      prq_type t;
      t = (p + 64'sd536870912) >>> 30;
      return cordic_word_type'(t);
   endfunction

   prq_type         m1_pr1_ff, m1_pr2_ff, m1_pr3_ff;
   logic            m1_neg_ff;
   cordic_word_type m2_q1_ff, m2_q2_ff, m2_q3_ff;
   prq_type         m3_pr4_ff;
   cordic_word_type m3_q1_ff;
   cordic_word_type m3_q4;
   logic [A_W-1:0]  m4_a_ff;
   logic            m_valid_ff [1:4];

   logic signed [CORDIC_W:0] a_sum;

   assign m3_q4 = round_q30(m3_pr4_ff);
   assign a_sum = {m3_q1_ff[CORDIC_W-1], m3_q1_ff}
                + {m3_q4[CORDIC_W-1], m3_q4};

   always_ff @(posedge clock) begin
      if (en) begin
         m1_pr1_ff <= prq_type'(rot_y[0]) * prq_type'(rot_y[0]);
         m1_pr2_ff <= prq_type'(rot_y[1]) * prq_type'(rot_y[1]);
         m1_pr3_ff <= prq_type'(rot_x[2]) * prq_type'(rot_x[3]);
         m1_neg_ff <= cneg_line_ff[CORDIC_STAGES-1][0] ^ cneg_line_ff[CORDIC_STAGES-1][1];
         m2_q1_ff  <= round_q30(m1_pr1_ff);
         m2_q2_ff  <= round_q30(m1_pr2_ff);
         m2_q3_ff  <= round_q30(m1_neg_ff ? -m1_pr3_ff : m1_pr3_ff);
         m3_pr4_ff <= prq_type'(m2_q2_ff) * prq_type'(m2_q3_ff);
         m3_q1_ff  <= m2_q1_ff;
         // clamp the term into [0, 1]
         if (a_sum[CORDIC_W]) begin
            m4_a_ff <= '0;
         end else if (a_sum > (CORDIC_W+1)'(Q30_ONE)) begin
            m4_a_ff <= Q30_ONE;
         end else begin
            m4_a_ff <= a_sum[A_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= 4; k++) begin
            m_valid_ff[k] <= 1'b0;
         end
      end else if (en) begin
         m_valid_ff[1] <= rot_valid;
         for (int k = 2; k <= 4; k++) begin
            m_valid_ff[k] <= m_valid_ff[k-1];
         end
      end
   end

   // ------------------------------------------- square roots, one digit a stage
   // lane 0: sqrt(a), lane 1: sqrt(1 - a), both on Q60 operands
   logic [SQ_W-1:0] sq_init [2];
   logic [SQ_W-1:0] sq_v_ff [SQRT_STEPS][2];
   logic [SQ_W-1:0] sq_r_ff [SQRT_STEPS][2];
   logic            sq_valid_ff [SQRT_STEPS];

   assign sq_init[0] = SQ_W'({m4_a_ff, 30'b0});
   assign sq_init[1] = SQ_W'({Q30_ONE - m4_a_ff, 30'b0});

   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
      localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - j));

      logic sq_valid_src;

      if (j == 0) begin : g_vhead
         assign sq_valid_src = m_valid_ff[4];
      end else begin : g_vbody
         assign sq_valid_src = sq_valid_ff[j-1];
      end

      for (genvar l = 0; l < 2; l++) begin : g_lane
         logic [SQ_W-1:0] v_src;
         logic [SQ_W-1:0] r_src;
         logic [SQ_W-1:0] trial;

         if (j == 0) begin : g_head
            assign v_src = sq_init[l];
            assign r_src = '0;
         end else begin : g_body
            assign v_src = sq_v_ff[j-1][l];
            assign r_src = sq_r_ff[j-1][l];
         end

         assign trial = r_src + BIT;

         always_ff @(posedge clock) begin
            if (en) begin
               if (v_src >= trial) begin
                  sq_v_ff[j][l] <= v_src - trial;
                  sq_r_ff[j][l] <= (r_src >> 1) + BIT;
               end else begin
                  sq_v_ff[j][l] <= v_src;
                  sq_r_ff[j][l] <= r_src >> 1;
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[j] <= 1'b0;
         end else if (en) begin
            sq_valid_ff[j] <= sq_valid_src;
         end
      end
   end

   // ------------------------------------------------------ atan2 CORDIC
   cordic_word_type vec_x_src [1];
   cordic_word_type vec_y_src [1];
   cordic_word_type vec_z_src [1];
   cordic_word_type vec_x [1];
   cordic_word_type vec_y [1];
   cordic_word_type vec_z [1];
   logic            vec_valid;

   assign vec_x_src[0] = cordic_word_type'(sq_r_ff[SQRT_STEPS-1][1][A_W-1:0]);
   assign vec_y_src[0] = cordic_word_type'(sq_r_ff[SQRT_STEPS-1][0][A_W-1:0]);
   assign vec_z_src[0] = '0;

   hdu_cordic #(
      .STAGES    (CORDIC_STAGES),
      .LANES     (1),
      .VECTORING (1'b1)
   ) u_vec (
      .clock     (clock),
      .reset     (reset),
      .enable    (en),
      .in_valid  (sq_valid_ff[SQRT_STEPS-1]),
      .in_x      (vec_x_src),
      .in_y      (vec_y_src),
      .in_z      (vec_z_src),
      .out_valid (vec_valid),
      .out_x     (vec_x),
      .out_y     (vec_y),
      .out_z     (vec_z)
   );

   // ---------------------------------------------------- distance scaling
   logic [DP_W-1:0]   d1_prod_ff;
   logic              d1_valid_ff;
   logic [DIST_W-1:0] d_full;
   logic [DP_W-1:0]   d_round;

   assign d_round = (d1_prod_ff + DP_W'(64'd536870912)) >> 30;
   assign d_full  = d_round[DIST_W-1:0];

   always_ff @(posedge clock) begin
      if (en) begin
         // a negative angle counts as zero
         d1_prod_ff <= vec_z[0][CORDIC_W-1] ? '0
                     : DP_W'(vec_z[0][30:0]) * DP_W'(DIST_SCALE);
         // saturate at half the circumference
         d_ff <= (d_round > DP_W'(DIST_MAX)) ? DIST_MAX : d_full;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_valid_ff <= 1'b0;
         d_valid_ff  <= 1'b0;
      end else if (en) begin
         d1_valid_ff <= vec_valid;
         d_valid_ff  <= d1_valid_ff;
      end
   end

   // ------------------------------------------------------- output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!out_valid_ff || !rsp_stall) begin
         out_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || !rsp_stall) begin
         out_dist_ff <= d_ff;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_distance_km = out_dist_ff;

   // ------------------------------------------------------------ assertions
   a_dist_saturated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_distance_km <= DIST_MAX))
      else $error("distance beyond half the circumference");

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_full_pipe_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall && d_valid_ff) |-> req_stall)
      else $error("item taken while the pipe is blocked");

   a_clamped_term: assert property (@(posedge clock) disable iff (reset)
      m_valid_ff[4] |-> (m4_a_ff <= Q30_ONE))
      else $error("haversine term above one");

endmodule

`default_nettype wire

[test/tb.sv]
// Self-checking testbench for haversine_distance_unit: queued query items,
// a bit-accurate CORDIC distance predictor and random stalls on both sides.
// Depends on hdu_pkg and the unit under test.
`timescale 1ns / 1ps

module tb;
   import hdu_pkg::*;

   localparam int LAT_MAX = 94371840;
   localparam int LON_MAX = 188743680;
   localparam longint PI_FX = 64'd3373259426;
   localparam longint GAIN_FX = 652032874;
   localparam longint ONE_FX = 64'd1073741824;
   localparam int N_STAGES = 24;

   typedef struct packed {
      logic signed [LAT_W-1:0] lat;
      logic signed [LON_W-1:0] lon;
   } query_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [LAT_W-1:0] req_query_latitude = '0;
   logic signed [LON_W-1:0] req_query_longitude = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   logic [DIST_W-1:0] rsp_distance_km;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   // our own copy of the reference point
   logic signed [LAT_W-1:0] home_lat = '0;
   logic signed [LON_W-1:0] home_lon = '0;

   query_type pending_q[$];
   logic [DIST_W-1:0] distance_q[$];
   int errors = 0;
   int send_gap = 0;
   int recv_gap = 0;
   int hold_left = 0;
   logic calm = 1'b0;   // no idling on either side
   logic hold_go = 1'b0;

   haversine_distance_unit uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------- predictor ----------------
   function automatic longint arctan_step(input int i);
      longint tab [10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                           33543516, 16775851, 8388437, 4194283, 2097149};
      if (i < 10) return tab[i];
      if (i <= 30) return longint'(1) << (30 - i);
      return 0;
   endfunction

   function automatic longint round_mul(input longint a, input longint b);
      return (a * b + (longint'(1) << 29)) >>> 30;
   endfunction

   // sine and cosine of an angle in degrees * 2^fb
   function automatic void rotate_angle(input longint ang, input int fb,
                                        output longint s, output longint c);
      longint per, half, quarter, r, rad, x, y, z, xs, ys;
      longint unsigned m, dv;
      bit cneg;
      per = longint'(360) << fb;
      half = per / 2;
      quarter = per / 4;
      cneg = 1'b0;
      r = ang % per;
      if (r < 0) r += per;
      if (r >= half) r -= per;
      if (r > quarter) begin
         r = half - r;
         cneg = 1'b1;
      end else if (r < -quarter) begin
         r = -half - r;
         cneg = 1'b1;
      end
      m = (r < 0) ? longint'(-r) : r;
      dv = longint'(180) << fb;
      rad = (m * PI_FX + dv / 2) / dv;
      z = (r < 0) ? -rad : rad;
      x = GAIN_FX;
      y = 0;
      for (int i = 0; i < N_STAGES; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x -= ys; y += xs; z -= arctan_step(i);
         end else begin
            x += ys; y -= xs; z += arctan_step(i);
         end
      end
      s = y;
      c = cneg ? -x : x;
   endfunction

   function automatic longint unsigned int_root(input longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = longint'(1) << 62;
      for (int i = 0; i < 32; i++) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic longint vector_angle(input longint y, input longint x);
      longint z, xs, ys;
      z = 0;
      for (int i = 0; i < N_STAGES; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x += ys; y -= xs; z += arctan_step(i);
         end else begin
            x -= ys; y += xs; z -= arctan_step(i);
         end
      end
      return z;
   endfunction

   function automatic logic [DIST_W-1:0] great_circle(input query_type q);
      longint qlat, qlon, rlat, rlon, s1, s2, c1, c2, dum, a, z;
      longint unsigned d;
      qlat = longint'(q.lat);
      qlon = longint'(q.lon);
      rlat = longint'(home_lat);
      rlon = longint'(home_lon);
      rotate_angle(qlat - rlat, ANGLE_FRAC_BITS + 1, s1, dum);
      rotate_angle(qlon - rlon, ANGLE_FRAC_BITS + 1, s2, dum);
      rotate_angle(rlat, ANGLE_FRAC_BITS, dum, c1);
      rotate_angle(qlat, ANGLE_FRAC_BITS, dum, c2);
      a = round_mul(s1, s1) + round_mul(round_mul(s2, s2), round_mul(c1, c2));
      // clamp the haversine term into [0,1]
      if (a < 0) a = 0;
      if (a > ONE_FX) a = ONE_FX;
      z = vector_angle(int_root(a << 30), int_root((ONE_FX - a) << 30));
      if (z < 0) z = 0;
      d = (longint'(z) * 64'd3261952 + (64'd1 << 29)) >> 30;
      // saturate at half the circumference
      if (d > 64'd5123863) d = 64'd5123863;
      return d[DIST_W-1:0];
   endfunction

   // ---------------- driver ----------------
   // Pop the next item when the gap has run out; keep valid high across
   // back-to-back items so it takes only one assignment per edge.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            distance_q = {distance_q,
                          great_circle({req_query_latitude, req_query_longitude})};
            send_gap = calm ? 0 : $urandom_range(6);
         end
         if ((!req_valid || !req_stall)) begin
            if (send_gap == 0 && pending_q.size() > 0) begin
               query_type q;
               q = pending_q.pop_front();
               req_valid <= 1'b1;
               req_query_latitude <= q.lat;
               req_query_longitude <= q.lon;
            end else begin
               req_valid <= 1'b0;
               if (send_gap > 0) send_gap--;
            end
         end
      end
   end

   // ---------------- monitor ----------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b1;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (distance_q.size() == 0) begin
               $display("%0t: unexpected item, expected none, actual %0d",
                        $time, rsp_distance_km);
               errors++;
            end else begin
               logic [DIST_W-1:0] want;
               want = distance_q.pop_front();
               if (want !== rsp_distance_km) begin
                  $display("%0t: distance_km mismatch, expected %0d, actual %0d",
                           $time, want, rsp_distance_km);
                  errors++;
               end
            end
            recv_gap = calm ? 0 : $urandom_range(6);
         end
         // a long hold-off fills the pipe and pushes back on the sender
         if (hold_go && hold_left == 0) hold_left = 400;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------- sequencer ----------------
   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= CSR_ADDR_W'(idx) << 2;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (idx == CSR_REF_LATITUDE) home_lat = value[LAT_W-1:0];
      else home_lon = value[LON_W-1:0];
   endtask

   task automatic drain;
      while (pending_q.size() > 0 || req_valid || distance_q.size() > 0)
         @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic queue_item(input int lat, input int lon);
      query_type q;
      q.lat = LAT_W'(lat);
      q.lon = LON_W'(lon);
      pending_q = {pending_q, q};
   endtask

   task automatic queue_random(input int n);
      int lat, lon;
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(4) == 0) begin
            // full-width values, well beyond the poles and the date line
            lat = $urandom;
            lon = $urandom;
         end else begin
            lat = int'($urandom_range(2 * LAT_MAX)) - LAT_MAX;
            lon = int'($urandom_range(2 * LON_MAX)) - LON_MAX;
         end
         queue_item(lat, lon);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, zero distance, antipodes, over-the-pole angles
      write_reg(CSR_REF_LATITUDE, 0);
      write_reg(CSR_REF_LONGITUDE, 0);
      queue_item(0, 0);
      queue_item(0, LON_MAX);
      queue_item(0, -LON_MAX);
      queue_item(LAT_MAX, 0);
      queue_item(-LAT_MAX, 0);
      queue_item(LAT_MAX, LON_MAX);
      queue_item(-LAT_MAX, -LON_MAX);
      queue_item(32'h07FF_FFFF, 32'h0FFF_FFFF);
      queue_item(32'h0800_0000, 32'h1000_0000);
      queue_item(-1, -1);
      queue_item(1, 1);
      queue_item(LAT_MAX / 2, LON_MAX / 2);
      queue_item(0, LON_MAX - 1);
      drain();

      write_reg(CSR_REF_LATITUDE, LAT_MAX);
      write_reg(CSR_REF_LONGITUDE, LON_MAX);
      queue_item(LAT_MAX, LON_MAX);
      queue_item(-LAT_MAX, -LON_MAX);
      queue_item(0, 0);
      queue_item(32'h07FF_FFFF, 32'h1000_0000);
      queue_random(200);
      drain();

      // no idling, then a long receiver hold-off while items keep coming
      write_reg(CSR_REF_LATITUDE, -LAT_MAX);
      write_reg(CSR_REF_LONGITUDE, -LON_MAX);
      calm <= 1'b1;
      queue_item(LAT_MAX, LON_MAX);
      queue_item(-LAT_MAX, -LON_MAX);
      queue_random(200);
      @(posedge clock);
      hold_go <= 1'b1;
      @(posedge clock);
      hold_go <= 1'b0;
      drain();
      calm <= 1'b0;

      write_reg(CSR_REF_LATITUDE, 32'h07FF_FFFF);
      write_reg(CSR_REF_LONGITUDE, 32'h1000_0000);
      queue_random(200);
      drain();

      for (int p = 0; p < 3; p++) begin
         write_reg(CSR_REF_LATITUDE, int'($urandom_range(2 * LAT_MAX)) - LAT_MAX);
         write_reg(CSR_REF_LONGITUDE, $urandom);
         queue_random(170);
         drain();
      end

      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // hang guard, far beyond the slowest correct run
   initial begin
      #5ms;
      $display("FAILURE");
      $finish;
   end

endmodule

[sim.f]
sv/hdu_pkg.sv
sv/hdu_cordic.sv
sv/haversine_distance_unit.sv
test/tb.sv
